>>> sv/assert_macros.svh
// Assertion macros used by the cache tag store top level.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

>>> sv/sacl_pkg.sv
// Types and constants for the set-associative cache tag store.
// No dependencies.
`timescale 1ns / 1ps
package sacl_pkg;
  localparam logic [1:0] ST_HIT   = 2'd0;
  localparam logic [1:0] ST_FILL  = 2'd1;
  localparam logic [1:0] ST_EVICT = 2'd2;
  localparam logic [1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] CFG_LFU_MODE   = 2'd2;
  localparam logic [1:0] CFG_RSVD       = 2'd3;
  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_SCAN, S_WRITE, S_DONE
  } state_t;
  typedef struct packed {
    logic [63:0] tag;
    logic [63:0] blk;
    logic [63:0] stamp;
    logic [31:0] uses;
  } line_t;
endpackage

>>> sv/sacl_cmp.sv
// Shared victim compare unit: is candidate better than current best.
// Depends on sacl_pkg.
`timescale 1ns / 1ps
module sacl_cmp (
  input  logic           lfu,
  input  sacl_pkg::line_t cand,
  input  sacl_pkg::line_t best,
  output logic           better
);
  always_comb begin
    if (lfu) begin
      better = (cand.uses < best.uses) ||
               ((cand.uses == best.uses) && (cand.stamp < best.stamp));
    end else begin
      better = cand.stamp < best.stamp;
    end
  end
endmodule

>>> sv/set_assoc_cache_lru_lfu_core.sv
// Set-associative cache tag store with LRU / LFU replacement, top level.
// Depends on sacl_pkg, sacl_cmp and assert_macros.svh.
// Steps per lookup: READ, SCAN over the ways, WRITE, DONE; the next start is taken in IDLE.
// The way scan walks one way per cycle through the shared compare unit.
// Synchronous active-low reset clears line and set clock valid bits and totals, and loads default config.
// Results are strobed for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module set_assoc_cache_lru_lfu_core #(
  parameter int WAYS         = 4,
  parameter int MAX_SET_BITS = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_addr,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [63:0] out_victim_block,
  output logic [63:0] out_insert_block,
  output logic [31:0] out_hits_total,
  output logic [31:0] out_misses_total,
  output logic [31:0] out_evictions_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int WB     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SB     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NSETS  = 1 << SB;
  localparam int CB     = $clog2(WAYS + 1);
  localparam int LB     = SB + WB;
  localparam int NLINES = 1 << LB;

  sacl_pkg::state_t state_r, state_nxt;
  logic [2:0]  set_bits_r;
  logic [3:0]  block_bits_r;
  logic        lfu_r;
  logic [63:0] tag_r, blk_r, clk_r;
  logic [SB-1:0] set_r;
  logic [CB-1:0] way_r;
  logic [WB-1:0] hit_w_r, free_w_r, vic_w_r;
  logic        hit_f_r, free_f_r;
  sacl_pkg::line_t best_r;
  logic [31:0] hits_r, miss_r, evs_r;
  logic [1:0]  status_r;
  logic [63:0] victim_r, ins_r;
  logic [63:0] setclk_q [NSETS];
  logic [NSETS-1:0] setv_r;
  logic [63:0] sclk_rd_r;
  sacl_pkg::line_t mem [NLINES];
  sacl_pkg::line_t rd_r, hit_line_r;
  logic [NLINES-1:0] vbits_r;

  logic [2:0]  sb_eff;
  logic [6:0]  shamt;
  logic [63:0] set_full;
  logic        better;
  logic [LB-1:0] rd_addr, wr_addr;
  logic        cur_valid;
  logic [WB-1:0] prev_w;
  logic [63:0] clk_inc;
  logic [31:0] uses_inc;
  sacl_pkg::line_t wr_line;

  always_comb begin
    sb_eff = ({1'b0, set_bits_r} > 4'(MAX_SET_BITS)) ? 3'(MAX_SET_BITS) : set_bits_r;
    shamt = 7'(sb_eff) + 7'(block_bits_r);
    set_full = (in_addr >> block_bits_r) & ((64'd1 << sb_eff) - 64'd1);
  end

  always_comb begin
    clk_inc  = (setv_r[set_r] ? sclk_rd_r : 64'd0) + 64'd1;
    uses_inc = (hit_line_r.uses != 32'hFFFF_FFFF) ? hit_line_r.uses + 32'd1
                                                  : hit_line_r.uses;
    if (hit_f_r) begin
      wr_line = '{tag: hit_line_r.tag, blk: hit_line_r.blk, stamp: clk_r, uses: uses_inc};
    end else begin
      wr_line = '{tag: tag_r, blk: blk_r, stamp: clk_r, uses: 32'd1};
    end
  end

  assign busy      = (state_r != sacl_pkg::S_IDLE);
  assign cfg_ready = (state_r == sacl_pkg::S_IDLE) && !start;
  assign rd_addr   = LB'({set_r, WB'(way_r)} );
  assign prev_w    = WB'(way_r - CB'(1));
  assign cur_valid = vbits_r[LB'({set_r, prev_w})];
  assign wr_addr   = LB'({set_r, hit_f_r ? hit_w_r : (free_f_r ? free_w_r : vic_w_r)});

  sacl_cmp u_cmp (.lfu(lfu_r), .cand(rd_r), .best(best_r), .better(better));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sacl_pkg::S_IDLE:  if (start) state_nxt = sacl_pkg::S_READ;
      sacl_pkg::S_READ:  state_nxt = sacl_pkg::S_SCAN;
      sacl_pkg::S_SCAN:  if (way_r == CB'(WAYS)) state_nxt = sacl_pkg::S_WRITE;
      sacl_pkg::S_WRITE: state_nxt = sacl_pkg::S_DONE;
      sacl_pkg::S_DONE:  state_nxt = sacl_pkg::S_IDLE;
      default:           state_nxt = sacl_pkg::S_IDLE;
    endcase
  end

  // memory ports: one line read per cycle, set clock read on accept
  always_ff @(posedge clk) begin
    rd_r <= mem[rd_addr];
    if (state_r == sacl_pkg::S_IDLE && start) sclk_rd_r <= setclk_q[SB'(set_full)];
    if (state_r == sacl_pkg::S_READ) setclk_q[set_r] <= clk_inc;
    if (state_r == sacl_pkg::S_WRITE) mem[wr_addr] <= wr_line;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sacl_pkg::S_IDLE;
      set_bits_r <= 3'd4; block_bits_r <= 4'd4; lfu_r <= 1'b0;
      hits_r <= '0; miss_r <= '0; evs_r <= '0;
      vbits_r <= '0;
      setv_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid <= (state_r == sacl_pkg::S_DONE);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sacl_pkg::CFG_SET_BITS:   set_bits_r   <= cfg_data[2:0];
          sacl_pkg::CFG_BLOCK_BITS: block_bits_r <= cfg_data[3:0];
          sacl_pkg::CFG_LFU_MODE:   lfu_r        <= cfg_data[0];
          default: ;
        endcase
      end
      case (state_r)
        sacl_pkg::S_IDLE: if (start) begin
          set_r <= SB'(set_full);
          tag_r <= in_addr >> shamt;
          blk_r <= in_addr & ~((64'd1 << block_bits_r) - 64'd1);
          way_r <= '0;
          hit_f_r <= 1'b0; free_f_r <= 1'b0; vic_w_r <= '0;
        end
        sacl_pkg::S_READ: begin
          clk_r <= clk_inc;
          setv_r[set_r] <= 1'b1;
          way_r <= way_r + CB'(1);
        end
        sacl_pkg::S_SCAN: begin
          if (way_r != CB'(WAYS)) way_r <= way_r + CB'(1);
          if (cur_valid && rd_r.tag == tag_r && !hit_f_r) begin
            hit_f_r <= 1'b1; hit_w_r <= prev_w; hit_line_r <= rd_r;
          end
          if (!cur_valid && !free_f_r) begin
            free_f_r <= 1'b1; free_w_r <= prev_w;
          end
          if (prev_w == '0 || better) begin
            best_r <= rd_r; vic_w_r <= prev_w;
          end
        end
        sacl_pkg::S_WRITE: begin
          vbits_r[wr_addr] <= 1'b1;
          if (hit_f_r) begin
            status_r <= sacl_pkg::ST_HIT; victim_r <= '0; ins_r <= '0;
            hits_r <= hits_r + 32'd1;
          end else if (free_f_r) begin
            status_r <= sacl_pkg::ST_FILL; victim_r <= '0; ins_r <= blk_r;
            miss_r <= miss_r + 32'd1;
          end else begin
            status_r <= sacl_pkg::ST_EVICT; victim_r <= best_r.blk; ins_r <= blk_r;
            miss_r <= miss_r + 32'd1; evs_r <= evs_r + 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_status          = status_r;
  assign out_victim_block    = victim_r;
  assign out_insert_block    = ins_r;
  assign out_hits_total      = hits_r;
  assign out_misses_total    = miss_r;
  assign out_evictions_total = evs_r;

  `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `ASSERT_IMPL(a_out_idle, clk, rst_n, out_valid, state_r == sacl_pkg::S_IDLE)
  `ASSERT_IMPL(a_cfg_idle, clk, rst_n, cfg_valid && cfg_ready, !busy)
endmodule

>>> verif/set_assoc_cache_lru_lfu_checker.sv
// Checker for the set-associative cache tag store: watches the command,
// result and register channels, predicts each result and compares it.
// Depends on sacl_pkg for status codes and register indexes.
`timescale 1ns / 1ps
module set_assoc_cache_lru_lfu_checker #(
  parameter int WAYS         = 4,
  parameter int MAX_SET_BITS = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [63:0] in_addr,
  input  logic        out_valid,
  input  logic [1:0]  out_status,
  input  logic [63:0] out_victim_block,
  input  logic [63:0] out_insert_block,
  input  logic [31:0] out_hits_total,
  input  logic [31:0] out_misses_total,
  input  logic [31:0] out_evictions_total,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          n_hit,
  output int          n_fill,
  output int          n_evict
);
  localparam int NWAYS = WAYS;
  localparam int NSETS = 1 << MAX_SET_BITS;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] victim;
    logic [63:0] insert;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evicts;
  } lookup_t;

  lookup_t     expected_q[$];
  logic        tv[NSETS*NWAYS];
  logic [63:0] ttag[NSETS*NWAYS];
  logic [63:0] tblk[NSETS*NWAYS];
  logic [63:0] tstamp[NSETS*NWAYS];
  logic [31:0] tuses[NSETS*NWAYS];
  logic [63:0] sclk[NSETS];
  logic [31:0] hcnt, mcnt, ecnt;
  logic [2:0]  set_bits;
  logic [3:0]  block_bits;
  logic        lfu;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic lookup_t predict_lookup(input logic [63:0] a);
    int sb, bb, base, hw, fw, v, s, b, si;
    logic [63:0] blk, st, tg, c;
    logic better;
    lookup_t r;
    sb = (set_bits > MAX_SET_BITS) ? MAX_SET_BITS : set_bits;
    bb = block_bits;
    blk = a & ~((64'd1 << bb) - 64'd1);
    st = (a >> bb) & ((64'd1 << sb) - 64'd1);
    tg = a >> (sb + bb);
    si = int'(st);
    base = si * NWAYS;
    sclk[si] = sclk[si] + 64'd1;
    c = sclk[si];
    hw = -1;
    fw = -1;
    r = '0;
    for (int w = 0; w < NWAYS; w++) begin
      if (tv[base+w] && ttag[base+w] == tg && hw < 0) hw = w;
      if (!tv[base+w] && fw < 0) fw = w;
    end
    if (hw >= 0) begin
      tstamp[base+hw] = c;
      if (tuses[base+hw] != 32'hFFFF_FFFF) tuses[base+hw]++;
      r.status = sacl_pkg::ST_HIT;
      hcnt++;
    end else begin
      if (fw >= 0) begin
        v = fw;
        r.status = sacl_pkg::ST_FILL;
      end else begin
        v = 0;
        for (int w = 1; w < NWAYS; w++) begin
          s = base + w;
          b = base + v;
          if (lfu)
            better = tuses[s] < tuses[b] || (tuses[s] == tuses[b] && tstamp[s] < tstamp[b]);
          else
            better = tstamp[s] < tstamp[b];
          if (better) v = w;
        end
        r.status = sacl_pkg::ST_EVICT;
        r.victim = tblk[base+v];
        ecnt++;
      end
      tv[base+v] = 1'b1;
      ttag[base+v] = tg;
      tblk[base+v] = blk;
      tstamp[base+v] = c;
      tuses[base+v] = 32'd1;
      r.insert = blk;
      mcnt++;
    end
    r.hits = hcnt;
    r.misses = mcnt;
    r.evicts = ecnt;
    return r;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
    n_hit = 0;
    n_fill = 0;
    n_evict = 0;
  end

  always @(posedge clk) begin
    lookup_t e;
    if (!rst_n) begin
      for (int i = 0; i < NSETS*NWAYS; i++) tv[i] = 1'b0;
      for (int i = 0; i < NSETS; i++) sclk[i] = '0;
      hcnt = '0;
      mcnt = '0;
      ecnt = '0;
      set_bits = 3'd4;
      block_bits = 4'd4;
      lfu = 1'b0;
      expected_q.delete();
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", 64'(out_status), 64'd0);
        end else begin
          e = expected_q.pop_front();
          if (out_status != e.status) report("status", 64'(out_status), 64'(e.status));
          if (out_victim_block != e.victim) report("victim", out_victim_block, e.victim);
          if (out_insert_block != e.insert) report("insert", out_insert_block, e.insert);
          if (out_hits_total != e.hits) report("hits", 64'(out_hits_total), 64'(e.hits));
          if (out_misses_total != e.misses)
            report("misses", 64'(out_misses_total), 64'(e.misses));
          if (out_evictions_total != e.evicts)
            report("evictions", 64'(out_evictions_total), 64'(e.evicts));
          case (e.status)
            sacl_pkg::ST_HIT:  n_hit++;
            sacl_pkg::ST_FILL: n_fill++;
            default: n_evict++;
          endcase
        end
      end
      if (start && !busy) expected_q.push_back(predict_lookup(in_addr));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sacl_pkg::CFG_SET_BITS:   set_bits = cfg_data[2:0];
          sacl_pkg::CFG_BLOCK_BITS: block_bits = cfg_data[3:0];
          sacl_pkg::CFG_LFU_MODE:   lfu = cfg_data[0];
          default: ;
        endcase
      end
    end
    pending = expected_q.size();
  end
endmodule

>>> verif/set_assoc_cache_lru_lfu_core_test.sv
// Top of the cache tag store test: clock, reset, register writes and
// bursty lookup stimulus; the checker predicts and compares results.
// Depends on sacl_pkg, set_assoc_cache_lru_lfu_core and the checker.
`timescale 1ns / 1ps
module set_assoc_cache_lru_lfu_core_test;
  localparam int WAYS         = 4;
  localparam int MAX_SET_BITS = 6;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] in_addr = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [63:0] out_victim_block, out_insert_block;
  logic [31:0] out_hits_total, out_misses_total, out_evictions_total;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          errors, pending, n_hit, n_fill, n_evict;
  logic [63:0] hot[16];

  always #2 clk = ~clk;

  set_assoc_cache_lru_lfu_core #(.WAYS(WAYS), .MAX_SET_BITS(MAX_SET_BITS)) dut (.*);
  set_assoc_cache_lru_lfu_checker #(.WAYS(WAYS), .MAX_SET_BITS(MAX_SET_BITS)) chk (.*);

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic lookup(input logic [63:0] a);
    start <= 1'b1;
    in_addr <= a;
    do @(posedge clk); while (busy);
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_mode(input int sb, input int bb, input int lf);
    settle();
    write_reg(sacl_pkg::CFG_SET_BITS, 32'(sb));
    write_reg(sacl_pkg::CFG_BLOCK_BITS, 32'(bb));
    write_reg(sacl_pkg::CFG_LFU_MODE, 32'(lf));
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic run_phase(input int count);
    int burst;
    logic [63:0] a;
    for (int k = 0; k < 16; k++) hot[k] = rand64();
    while (count > 0) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && count > 0) begin
        case ($urandom_range(0, 9))
          0, 1:    a = rand64();
          2:       a = {$urandom(), $urandom()} & 64'hFFF;
          default: a = hot[$urandom_range(0, 15)] ^ 64'($urandom_range(0, 63));
        endcase
        lookup(a);
        burst--;
        count--;
      end
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  initial begin
    #2000000;
    $display("** set_assoc_cache_lru_lfu_core: FAILED **");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    lookup(64'h0);
    lookup(64'hFFFF_FFFF_FFFF_FFFF);
    lookup(64'h0);
    for (int i = 1; i <= 5; i++) lookup(64'h1000 * i);
    lookup(64'h1000);
    lookup(64'h8000_0000_0000_0000);
    set_mode(7, 15, 1);
    for (int i = 0; i < 6; i++) lookup({4'($urandom_range(0, 5)), 60'h0});
    lookup(64'h5555_5555_5555_5555);
    lookup(64'hAAAA_AAAA_AAAA_AAAA);
    set_mode(0, 0, 0);
    lookup(64'h1);
    lookup(64'h2);
    lookup(64'h3);
    lookup(64'h4);
    lookup(64'h5);
    lookup(64'h1);
    write_reg(sacl_pkg::CFG_RSVD, 32'hFFFF_FFFF);
    set_mode(6, 12, 1);
    run_phase(300);
    set_mode(2, 6, 0);
    run_phase(300);
    set_mode(0, 4, 1);
    run_phase(300);
    set_mode(6, 0, 0);
    run_phase(300);
    set_mode($urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 1));
    run_phase(400);
    settle();
    $display("lookups checked: %0d hits, %0d fills, %0d evictions", n_hit, n_fill, n_evict);
    $display("covered LRU and LFU replacement over several set and block splits");
    if (errors == 0) begin
      $display("** set_assoc_cache_lru_lfu_core: PASSED **");
    end else begin
      $display("** set_assoc_cache_lru_lfu_core: FAILED **");
    end
    $finish;
  end
endmodule
